// ===== rtl/core/kclt_pkg.sv =====
// ----------------------------------------------------------------------------
// kclt_pkg
// Types and codes shared by the keyed compacting list table.
// ----------------------------------------------------------------------------
package kclt_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    typedef logic [OP_W-1:0]         opcode_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [HANDLE_W-1:0]     handle_t;
    typedef logic [STATUS_W-1:0]     status_t;
    typedef logic [TOTAL_W-1:0]      total_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_SEARCH = 2'd2;

    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_DUP  = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_MISS = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic load_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/kclt_if.sv =====
// ----------------------------------------------------------------------------
// kclt_if
// Request and response channels of the keyed compacting list table.
// ----------------------------------------------------------------------------
interface kclt_req_if;
    logic              valid;
    logic              ready;
    kclt_pkg::opcode_t opcode;
    kclt_pkg::key_t    key;
    kclt_pkg::handle_t item_handle;

    modport source (output valid, output opcode, output key, output item_handle,
                    input ready);
    modport sink   (input valid, input opcode, input key, input item_handle,
                    output ready);
endinterface

interface kclt_rsp_if;
    logic              valid;
    logic              ready;
    kclt_pkg::status_t status;
    kclt_pkg::handle_t found_handle;
    kclt_pkg::total_t  entry_total;

    modport source (output valid, output status, output found_handle,
                    output entry_total, input ready);
    modport sink   (input valid, input status, input found_handle,
                    input entry_total, output ready);
endinterface

// ===== rtl/core/kclt_cell.sv =====
// ----------------------------------------------------------------------------
// kclt_cell
// One list slot: holds a key and handle, compares against the request key,
// takes its upper neighbour's entry on compaction or a new entry on insert.
// ----------------------------------------------------------------------------
module kclt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kclt_pkg::cell_ctrl_t ctrl,
    input  logic                 live,
    input  kclt_pkg::key_t       cmp_key,
    input  kclt_pkg::key_t       load_key,
    input  kclt_pkg::handle_t    load_handle,
    input  kclt_pkg::key_t       nbr_key,
    input  kclt_pkg::handle_t    nbr_handle,
    output kclt_pkg::key_t       key,
    output kclt_pkg::handle_t    handle,
    output logic                 match,
    output kclt_pkg::handle_t    sel_handle
);

    kclt_pkg::key_t    key_reg;
    kclt_pkg::key_t    key_next;
    kclt_pkg::handle_t handle_reg;
    kclt_pkg::handle_t handle_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctrl.load_en)
        begin
            key_next    = load_key;
            handle_next = load_handle;
        end
        else if (ctrl.shift_en)
        begin
            key_next    = nbr_key;
            handle_next = nbr_handle;
        end
    end

    assign match_next = ctrl.cmp_en ? (live && (key_reg == cmp_key)) : match_reg;

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key        = key_reg;
    assign handle     = handle_reg;
    assign match      = match_reg;
    assign sel_handle = match_reg ? handle_reg : '0;

endmodule

// ===== rtl/core/keyed_compacting_list_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_compacting_list_table_unit
// List of up to CAPACITY (key, handle) entries kept densely in arrival order.
//
// Each request goes from acceptance to a result in the output register in
// steps: every cell compares its key against the latched request, the cell
// results are merged, then the cells and count are updated. The update
// waits while an earlier result is still held on the output. The next
// request is taken in the cycle after the update, so none is accepted
// before the last is through, though one may be while a result still waits
// to be taken. Keys are unique in the list, so at most one cell matches; on
// remove every cell at or above the match takes its upper neighbour's entry
// in the same cycle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module keyed_compacting_list_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    kclt_req_if.sink    req,
    kclt_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    kclt_pkg::opcode_t op_reg;
    kclt_pkg::key_t    key_reg;
    kclt_pkg::handle_t handle_reg;

    logic              any_reg;
    kclt_pkg::handle_t found_reg;
    kclt_pkg::handle_t found_or;

    logic              out_valid_reg;
    logic              out_valid_next;
    kclt_pkg::status_t out_status_reg;
    kclt_pkg::status_t out_status_next;
    kclt_pkg::handle_t out_found_reg;
    kclt_pkg::handle_t out_found_next;
    kclt_pkg::total_t  out_total_reg;
    kclt_pkg::total_t  out_total_next;

    logic              in_fire;
    logic              out_free;
    logic              upd_fire;
    logic              do_insert;
    logic              do_remove;
    logic              list_full;

    logic [CAPACITY-1:0] match_vec;
    kclt_pkg::key_t      cell_key    [CAPACITY];
    kclt_pkg::handle_t   cell_handle [CAPACITY];
    kclt_pkg::handle_t   cell_sel    [CAPACITY];

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign upd_fire  = (state_reg == S_UPD) && out_free;
    assign list_full = (count_reg >= CNT_W'(CAPACITY));
    assign do_insert = upd_fire && (op_reg == kclt_pkg::OP_INSERT) && !any_reg && !list_full;
    assign do_remove = upd_fire && (op_reg == kclt_pkg::OP_REMOVE) && any_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CAPACITY-1:0] UPTO = {CAPACITY{1'b1}} >> (CAPACITY - 1 - gi);
            kclt_pkg::cell_ctrl_t ctrl;
            kclt_pkg::key_t       nbr_key;
            kclt_pkg::handle_t    nbr_handle;
            logic                 live;

            assign live          = (count_reg > CNT_W'(gi));
            assign ctrl.cmp_en   = (state_reg == S_CMP);
            assign ctrl.shift_en = do_remove && (|(match_vec & UPTO));
            assign ctrl.load_en  = do_insert && (count_reg == CNT_W'(gi));

            if (gi == CAPACITY - 1)
            begin : g_top
                assign nbr_key    = cell_key[gi];
                assign nbr_handle = cell_handle[gi];
            end
            else
            begin : g_mid
                assign nbr_key    = cell_key[gi+1];
                assign nbr_handle = cell_handle[gi+1];
            end

            kclt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .live        (live),
                .cmp_key     (key_reg),
                .load_key    (key_reg),
                .load_handle (handle_reg),
                .nbr_key     (nbr_key),
                .nbr_handle  (nbr_handle),
                .key         (cell_key[gi]),
                .handle      (cell_handle[gi]),
                .match       (match_vec[gi]),
                .sel_handle  (cell_sel[gi])
            );
        end
    endgenerate

    always_comb
    begin
        found_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_or = found_or | cell_sel[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_CMP;
            S_CMP:   state_next = S_RED;
            S_RED:   state_next = S_UPD;
            S_UPD:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        out_status_next = kclt_pkg::ST_MISS;
        out_found_next  = '0;
        case (op_reg)
            kclt_pkg::OP_INSERT:
            begin
                if (any_reg)
                begin
                    out_status_next = kclt_pkg::ST_DUP;
                    out_found_next  = found_reg;
                end
                else if (list_full)
                begin
                    out_status_next = kclt_pkg::ST_FULL;
                end
                else
                begin
                    out_status_next = kclt_pkg::ST_DONE;
                    count_next      = count_reg + 1'b1;
                end
            end
            kclt_pkg::OP_REMOVE:
            begin
                if (any_reg)
                begin
                    out_status_next = kclt_pkg::ST_DONE;
                    out_found_next  = found_reg;
                    count_next      = count_reg - 1'b1;
                end
            end
            kclt_pkg::OP_SEARCH:
            begin
                if (any_reg)
                begin
                    out_status_next = kclt_pkg::ST_DONE;
                    out_found_next  = found_reg;
                end
            end
            default:
            begin
                out_status_next = kclt_pkg::ST_MISS;
            end
        endcase
        out_total_next = kclt_pkg::TOTAL_W'(count_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (upd_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= req.opcode;
            key_reg    <= req.key;
            handle_reg <= req.item_handle;
        end
        if (state_reg == S_RED)
        begin
            any_reg   <= |match_vec;
            found_reg <= found_or;
        end
        if (upd_fire)
        begin
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_total_reg  <= out_total_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_handle = out_found_reg;
    assign rsp.entry_total  = out_total_reg;

endmodule

// ===== rtl/core/kclt_checker.sv =====
// ----------------------------------------------------------------------------
// kclt_checker
// Port-level checks on the keyed compacting list table responses.
// ----------------------------------------------------------------------------
module kclt_checker #(
    parameter int CAPACITY = 64
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input kclt_pkg::status_t status,
    input kclt_pkg::handle_t found_handle,
    input kclt_pkg::total_t  entry_total
);

    localparam kclt_pkg::total_t CAP_TOTAL = kclt_pkg::TOTAL_W'(CAPACITY);

    a_miss_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == kclt_pkg::ST_MISS) |-> (found_handle == '0))
        else $error("miss transaction carries a handle");

    a_full_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == kclt_pkg::ST_FULL) |->
            (found_handle == '0) && (entry_total == CAP_TOTAL))
        else $error("full transaction with wrong handle or count");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY > 127) || (entry_total <= CAP_TOTAL))
        else $error("entry total above capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_handle) && $stable(entry_total))
        else $error("stalled response changed");

endmodule

bind keyed_compacting_list_table_unit kclt_checker #(.CAPACITY(CAPACITY)) u_kclt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .found_handle (rsp.found_handle),
    .entry_total  (rsp.entry_total)
);
